FILE: hw/rtl/wrs_pkg.sv
// ----------------------------------------------------------------------------
// wrs_pkg: shared types and constants for the window receiver sequencer
// Result kinds, register indexes, field widths and the front-to-back
// command record.
// ----------------------------------------------------------------------------
package wrs_pkg;

    localparam int MAX_SLOTS_DEF  = 8;
    localparam int MAX_SLOTS_LIM  = 64;
    localparam int SLOT_IW        = $clog2(MAX_SLOTS_LIM);
    localparam int QUEUE_DEPTH    = 4;     // power of two, pointers wrap freely

    localparam int SEQ_W          = 16;
    localparam int HANDLE_W       = 16;
    localparam int LEN_W          = 11;
    localparam int WS_W           = 4;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_SEQ    = 1'b1;

    localparam logic [WS_W-1:0]  WS_RESET       = 4'd5;
    localparam logic [SEQ_W-1:0] LAST_SEQ_RESET = 16'd1;
    localparam logic [SEQ_W-1:0] SEQ_ONE        = 16'd1;

    typedef enum logic [1:0] {
        KIND_DELIVER = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_DROP    = 2'd2
    } t_kind;

    // One request worth of work for the back end: an optional slot write,
    // then an optional notice or gap ack, then an optional flush.
    typedef struct packed {
        logic                wr_en;
        logic [SLOT_IW-1:0]  slot;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                notice;
        logic                gap;
        logic [SEQ_W-1:0]    gap_ack;
        logic                flush;
        logic [SLOT_IW-1:0]  last_idx;
        logic [SEQ_W-1:0]    flush_ack;
        logic                fin;
    } t_cmd;

endpackage

FILE: hw/rtl/wrs_cmd_fifo.sv
// ----------------------------------------------------------------------------
// wrs_cmd_fifo: command queue between front and back
// Small register FIFO of command records; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module wrs_cmd_fifo import wrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;

    assign o_full  = (r_count == CNTW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/wrs_front.sv
// ----------------------------------------------------------------------------
// wrs_front: packet intake and classification
// Holds the window state (expected, base, slot valid bits, flags), sorts
// each packet and queues one command for every packet that is not dropped.
// ----------------------------------------------------------------------------
module wrs_front import wrs_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SEQ_W-1:0]    i_seq_num,
    input  logic                i_checksum_ok,
    input  logic [HANDLE_W-1:0] i_payload_handle,
    input  logic [LEN_W-1:0]    i_payload_len,
    input  logic [WS_W-1:0]     i_window_size,
    input  logic [SEQ_W-1:0]    i_last_seq,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_full
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam logic [MAX_SLOTS-1:0] BIT0 = MAX_SLOTS'(1);

    typedef enum logic [1:0] {
        F_IDLE,
        F_CLASS,
        F_RUN
    } t_fstate;

    t_fstate               r_state;
    logic [SEQ_W-1:0]      r_expected;
    logic [SEQ_W-1:0]      r_base;
    logic                  r_first_gap;
    logic                  r_done;
    logic [MAX_SLOTS-1:0]  r_valid;

    logic [SEQ_W-1:0]      r_seq;
    logic                  r_ok;
    logic [HANDLE_W-1:0]   r_handle;
    logic [LEN_W-1:0]      r_len;
    logic                  r_notice;
    logic                  r_gap;
    logic [SEQ_W-1:0]      r_gap_ack;
    logic [SW-1:0]         r_slot;

    logic [SEQ_W-1:0]      offset;
    logic [SW-1:0]         off_idx;
    logic                  drop;
    logic                  out_range;
    logic                  in_order;
    logic [MAX_SLOTS-1:0]  v_set;
    logic [CW-1:0]         exp_off;
    logic [CW-1:0]         run_len;
    logic [MAX_SLOTS-1:0]  run_mask;
    logic                  contig;
    logic [SEQ_W-1:0]      highest;
    logic [SEQ_W-1:0]      next_base;
    logic                  fin;
    logic                  flush;

    always_comb begin
        offset    = r_seq - r_base;
        off_idx   = offset[SW-1:0];
        drop      = r_done || !r_ok || (r_seq < r_expected);
        out_range = (offset >= SEQ_W'(MAX_SLOTS));
        in_order  = (r_seq == r_expected);
        v_set     = r_valid | (BIT0 << off_idx);

        // first hole above the new packet: next expected number
        exp_off = CW'(MAX_SLOTS);
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (!v_set[k] && (SW'(k) > off_idx)) begin
                exp_off = CW'(k);
            end
        end

        // leading run of valid slots from the base
        run_len = CW'(MAX_SLOTS);
        for (int k = MAX_SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                run_len = CW'(k);
            end
        end
        for (int k = 0; k < MAX_SLOTS; k++) begin
            run_mask[k] = (CW'(k) < run_len);
        end
        contig    = (r_valid == run_mask);
        next_base = r_base + SEQ_W'(run_len);
        highest   = next_base - SEQ_ONE;
        fin       = (highest == i_last_seq);
        flush     = !r_notice && (run_len != '0) && contig &&
                    ((SEQ_W'(run_len) >= SEQ_W'(i_window_size)) || fin);
    end

    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_RUN) && !i_full;

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_en     = !r_notice;
        o_cmd.slot      = SLOT_IW'(r_slot);
        o_cmd.handle    = r_handle;
        o_cmd.len       = r_len;
        o_cmd.notice    = r_notice;
        o_cmd.gap       = r_gap;
        o_cmd.gap_ack   = r_gap_ack;
        o_cmd.flush     = flush;
        o_cmd.last_idx  = SLOT_IW'(run_len - 1'b1);
        o_cmd.flush_ack = next_base;
        o_cmd.fin       = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_expected  <= SEQ_ONE;
            r_base      <= SEQ_ONE;
            r_first_gap <= 1'b1;
            r_done      <= 1'b0;
            r_valid     <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_seq    <= i_seq_num;
                        r_ok     <= i_checksum_ok;
                        r_handle <= i_payload_handle;
                        r_len    <= i_payload_len;
                        r_state  <= F_CLASS;
                    end
                end
                F_CLASS: begin
                    r_slot <= off_idx;
                    // gap ack only on the first out-of-order arrival
                    r_gap  <= !drop && !out_range && !in_order && r_first_gap;
                    if (drop) begin
                        r_state <= F_IDLE;
                    end else if (out_range) begin
                        r_notice <= 1'b1;
                        r_state  <= F_RUN;
                    end else begin
                        r_notice <= 1'b0;
                        r_valid  <= v_set;
                        if (in_order) begin
                            r_first_gap <= 1'b1;
                            r_expected  <= r_base + SEQ_W'(exp_off);
                        end else begin
                            r_gap_ack   <= r_expected;
                            r_first_gap <= 1'b0;
                        end
                        r_state <= F_RUN;
                    end
                end
                F_RUN: begin
                    if (!i_full) begin
                        if (flush) begin
                            r_valid    <= '0;
                            r_base     <= next_base;
                            r_expected <= next_base;
                            r_done     <= fin;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/wrs_back.sv
// ----------------------------------------------------------------------------
// wrs_back: command execution and result output
// Owns the slot descriptor store, writes slots, emits notices, gap acks,
// in-order deliveries and flush acks through a result register.
// ----------------------------------------------------------------------------
module wrs_back import wrs_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_kind,
    output logic [SEQ_W-1:0]    o_ack_num,
    output logic [HANDLE_W-1:0] o_out_handle,
    output logic [LEN_W-1:0]    o_out_len,
    output logic                o_transfer_done,
    output logic                o_last_of_run
);

    localparam int SW = $clog2(MAX_SLOTS);

    typedef enum logic [2:0] {
        B_IDLE,
        B_HEAD,
        B_READ,
        B_DLV,
        B_ACK
    } t_bstate;

    t_bstate             r_state;
    t_cmd                r_cmd;
    logic [SW-1:0]       r_idx;

    logic [HANDLE_W-1:0] r_mem_handle [MAX_SLOTS];
    logic [LEN_W-1:0]    r_mem_len    [MAX_SLOTS];
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [LEN_W-1:0]    r_rd_len;

    logic                r_out_valid;
    t_kind               r_kind;
    logic [SEQ_W-1:0]    r_ack;
    logic [HANDLE_W-1:0] r_handle;
    logic [LEN_W-1:0]    r_len;
    logic                r_done;
    logic                r_last;

    logic                out_free;
    logic                out_load;
    logic                mem_we;

    assign out_free = !r_out_valid || i_out_ready;
    // a result is loaded in any output state once the register is free
    assign out_load = out_free &&
                      ((r_state == B_HEAD) || (r_state == B_DLV) || (r_state == B_ACK));
    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign mem_we   = o_pop && i_cmd.wr_en;

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_kind;
    assign o_ack_num       = r_ack;
    assign o_out_handle    = r_handle;
    assign o_out_len       = r_len;
    assign o_transfer_done = r_done;
    assign o_last_of_run   = r_last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_handle[i_cmd.slot[SW-1:0]] <= i_cmd.handle;
            r_mem_len[i_cmd.slot[SW-1:0]]    <= i_cmd.len;
        end
        r_rd_handle <= r_mem_handle[r_idx];
        r_rd_len    <= r_mem_len[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        if (i_cmd.notice || i_cmd.gap) begin
                            r_state <= B_HEAD;
                        end else if (i_cmd.flush) begin
                            r_state <= B_READ;
                        end
                    end
                end
                B_HEAD: begin
                    if (out_free) begin
                        r_kind      <= r_cmd.notice ? KIND_DROP : KIND_ACK;
                        r_ack       <= r_cmd.notice ? '0 : r_cmd.gap_ack;
                        r_handle    <= '0;
                        r_len       <= '0;
                        r_done      <= 1'b0;
                        r_last      <= !r_cmd.flush;
                        r_state     <= r_cmd.flush ? B_READ : B_IDLE;
                    end
                end
                B_READ: begin
                    // store read of r_idx lands in r_rd_* at this edge
                    r_state <= B_DLV;
                end
                B_DLV: begin
                    if (out_free) begin
                        r_kind      <= KIND_DELIVER;
                        r_ack       <= '0;
                        r_handle    <= r_rd_handle;
                        r_len       <= r_rd_len;
                        r_done      <= 1'b0;
                        r_last      <= 1'b0;
                        if (r_idx == r_cmd.last_idx[SW-1:0]) begin
                            r_state <= B_ACK;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= B_READ;
                        end
                    end
                end
                B_ACK: begin
                    if (out_free) begin
                        r_kind      <= KIND_ACK;
                        r_ack       <= r_cmd.flush_ack;
                        r_handle    <= '0;
                        r_len       <= '0;
                        r_done      <= r_cmd.fin;
                        r_last      <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/window_receiver_sequencer.sv
// ----------------------------------------------------------------------------
// window_receiver_sequencer: windowed ARQ receive sequencer
// Drops bad, stale and out-of-range packets, buffers the rest by offset from the
// group base, sends gap acks and flushes contiguous runs in order with an ack.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                 payload
//  in        in   i_in_valid / o_in_ready   seq_num, checksum_ok, payload_handle,
//                                           payload_len
//  out       out  o_out_valid / i_out_ready kind, ack_num, out_handle, out_len,
//                                           transfer_done, last_of_run
//  cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  Front end steps through capture, classify and evaluate/queue for each
//  queued packet, and returns to idle after classify for a dropped one.
//  Back end: pops a command, then sends a notice or gap ack if any, a
//  slot store read then an output for each delivered descriptor, and a
//  flush ack; each delivery waits on the registered store read.
//  Synchronous active-low reset; no clearing pass, slot valid bits reset.
//  A 4-deep command queue lets the front keep taking packets while the back
//  waits on a stalled output.
// ----------------------------------------------------------------------------
module window_receiver_sequencer import wrs_pkg::*; #(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SEQ_W-1:0]      i_seq_num,
    input  logic                  i_checksum_ok,
    input  logic [HANDLE_W-1:0]   i_payload_handle,
    input  logic [LEN_W-1:0]      i_payload_len,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_kind,
    output logic [SEQ_W-1:0]      o_ack_num,
    output logic [HANDLE_W-1:0]   o_out_handle,
    output logic [LEN_W-1:0]      o_out_len,
    output logic                  o_transfer_done,
    output logic                  o_last_of_run,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WS_W-1:0]  r_window_size;
    logic [SEQ_W-1:0] r_last_seq;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd q_in;
    t_cmd q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WS_RESET;
            r_last_seq    <= LAST_SEQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_SIZE: r_window_size <= i_cfg_data[WS_W-1:0];
                CFG_LAST_SEQ:    r_last_seq    <= i_cfg_data[SEQ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    wrs_front #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_seq_num       (i_seq_num),
        .i_checksum_ok   (i_checksum_ok),
        .i_payload_handle(i_payload_handle),
        .i_payload_len   (i_payload_len),
        .i_window_size   (r_window_size),
        .i_last_seq      (r_last_seq),
        .o_push          (q_push),
        .o_cmd           (q_in),
        .i_full          (q_full)
    );

    wrs_cmd_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_cmd  (q_in),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_cmd  (q_out),
        .o_empty(q_empty)
    );

    wrs_back #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (q_out),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_ack_num      (o_ack_num),
        .o_out_handle   (o_out_handle),
        .o_out_len      (o_out_len),
        .o_transfer_done(o_transfer_done),
        .o_last_of_run  (o_last_of_run)
    );

`ifndef SYNTH
    // done only ever rides on the closing flush ack
    a_done_on_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_transfer_done) |-> (o_kind == KIND_ACK) && o_last_of_run)
        else $error("transfer_done outside a closing ack");

    // a flush always ends with its ack, so a delivery never closes a request
    a_dlv_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_DELIVER)) |-> !o_last_of_run)
        else $error("delivery marked last of run");

    a_drop_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_DROP)) |-> o_last_of_run && (o_ack_num == '0))
        else $error("drop notice not a lone result");
`endif

endmodule

FILE: tb/tb_window_receiver_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_receiver_sequencer: self-checking bench for the ARQ receive sequencer
// A scoreboard class keeps its own copy of the window state and predicts the
// deliveries, acks and drop notices of every accepted request. A directed pass
// covers drops, gap acks, duplicates and the window size corners. Random
// phases follow, each under its own register setting. Both sides stall at
// random, and the last phase completes the transfer.
// ----------------------------------------------------------------------------
module tb_window_receiver_sequencer;
    import wrs_pkg::*;

    localparam int SLOTS = MAX_SLOTS_DEF;

    typedef struct packed {
        t_kind               kind;
        logic [SEQ_W-1:0]    ack_num;
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    len;
        logic                fin;
        logic                last;
    } t_result;

    class window_scoreboard;
        logic [WS_W-1:0]     win_size;
        logic [SEQ_W-1:0]    last_seq;
        logic [SEQ_W-1:0]    next_seq;
        logic [SEQ_W-1:0]    base;
        bit                  gap_armed;
        bit                  finished;
        bit                  held [SLOTS];
        logic [HANDLE_W-1:0] held_handle [SLOTS];
        logic [LEN_W-1:0]    held_len [SLOTS];
        t_result             result_q [$];
        int                  errors;
        int                  reports;

        function new();
            win_size  = WS_RESET;
            last_seq  = LAST_SEQ_RESET;
            next_seq  = SEQ_ONE;
            base      = SEQ_ONE;
            gap_armed = 1'b1;
            finished  = 1'b0;
            errors    = 0;
            reports   = 0;
            for (int i = 0; i < SLOTS; i++) begin
                held[i] = 1'b0;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_WINDOW_SIZE) begin
                win_size = data[WS_W-1:0];
            end else begin
                last_seq = data[SEQ_W-1:0];
            end
        endfunction

        function void push(t_kind kind, logic [SEQ_W-1:0] ack, logic [HANDLE_W-1:0] handle,
                           logic [LEN_W-1:0] len, logic fin);
            t_result r;
            r.kind    = kind;
            r.ack_num = ack;
            r.handle  = handle;
            r.len     = len;
            r.fin     = fin;
            r.last    = 1'b0;
            result_q.push_back(r);
        endfunction

        function void note_request(logic [SEQ_W-1:0] seq, logic ok,
                                   logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len);
            int               start;
            int               count;
            bit               contiguous;
            logic [SEQ_W-1:0] offset;
            logic [SEQ_W-1:0] eo;
            logic [SEQ_W-1:0] highest;
            logic [SEQ_W-1:0] nxt;
            t_result          tail;
            start = result_q.size();
            if (finished || !ok || seq < next_seq) begin
                return;
            end
            offset = seq - base;
            if (offset >= SLOTS) begin
                push(KIND_DROP, '0, '0, '0, 1'b0);
            end else begin
                if (seq == next_seq) begin
                    gap_armed = 1'b1;
                    held[offset] = 1'b1;
                    // skip past requests already buffered ahead of the hole
                    do begin
                        next_seq = next_seq + SEQ_ONE;
                        eo = next_seq - base;
                    end while (eo < SLOTS && held[eo]);
                end else begin
                    if (gap_armed) begin
                        push(KIND_ACK, next_seq, '0, '0, 1'b0);
                    end
                    gap_armed = 1'b0;
                end
                held[offset]        = 1'b1;
                held_handle[offset] = handle;
                held_len[offset]    = len;

                count = 0;
                while (count < SLOTS && held[count]) begin
                    count++;
                end
                contiguous = 1'b1;
                for (int i = count; i < SLOTS; i++) begin
                    if (held[i]) begin
                        contiguous = 1'b0;
                    end
                end
                if (count > 0 && contiguous) begin
                    highest = base + SEQ_W'(count) - SEQ_ONE;
                    if (count >= int'(win_size) || highest == last_seq) begin
                        nxt = highest + SEQ_ONE;
                        for (int i = 0; i < count; i++) begin
                            push(KIND_DELIVER, '0, held_handle[i], held_len[i], 1'b0);
                        end
                        push(KIND_ACK, nxt, '0, '0, highest == last_seq);
                        for (int i = 0; i < SLOTS; i++) begin
                            held[i] = 1'b0;
                        end
                        base     = nxt;
                        next_seq = nxt;
                        if (highest == last_seq) begin
                            finished = 1'b1;
                        end
                    end
                end
            end
            if (result_q.size() > start) begin
                tail = result_q.pop_back();
                tail.last = 1'b1;
                result_q.push_back(tail);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (result_q.size() == 0) begin
                errors++;
                if (reports < 10) begin
                    reports++;
                    $display("unexpected result: kind=%0d ack=%0d handle=%h len=%0d fin=%b last=%b",
                             got.kind, got.ack_num, got.handle, got.len, got.fin, got.last);
                end
                return;
            end
            want = result_q.pop_front();
            if (want !== got) begin
                errors++;
                if (reports < 10) begin
                    reports++;
                    $display("mismatch: exp kind=%0d ack=%0d handle=%h len=%0d fin=%b last=%b",
                             want.kind, want.ack_num, want.handle, want.len, want.fin,
                             want.last);
                    $display("          got kind=%0d ack=%0d handle=%h len=%0d fin=%b last=%b",
                             got.kind, got.ack_num, got.handle, got.len, got.fin, got.last);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [SEQ_W-1:0]      seq_num = '0;
    logic                  checksum_ok = 1'b0;
    logic [HANDLE_W-1:0]   payload_handle = '0;
    logic [LEN_W-1:0]      payload_len = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            kind;
    logic [SEQ_W-1:0]      ack_num;
    logic [HANDLE_W-1:0]   out_handle;
    logic [LEN_W-1:0]      out_len;
    logic                  transfer_done;
    logic                  last_of_run;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    window_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int stall_left = 0;

    window_receiver_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_seq_num        (seq_num),
        .i_checksum_ok    (checksum_ok),
        .i_payload_handle (payload_handle),
        .i_payload_len    (payload_len),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_kind           (kind),
        .o_ack_num        (ack_num),
        .o_out_handle     (out_handle),
        .o_out_len        (out_len),
        .o_transfer_done  (transfer_done),
        .o_last_of_run    (last_of_run),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // result side: sample before driving ready for the next cycle
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_valid && out_ready) begin
            got.kind    = t_kind'(kind);
            got.ack_num = ack_num;
            got.handle  = out_handle;
            got.len     = out_len;
            got.fin     = transfer_done;
            got.last    = last_of_run;
            sb.check_result(got);
        end
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 99) < 15) begin
            stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_request(logic [SEQ_W-1:0] seq, logic ok,
                                logic [HANDLE_W-1:0] handle, logic [LEN_W-1:0] len);
        in_valid       <= 1'b1;
        seq_num        <= seq;
        checksum_ok    <= ok;
        payload_handle <= handle;
        payload_len    <= len;
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        sb.note_request(seq, ok, handle, len);
        if (!quiet && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic send_pkt(logic [SEQ_W-1:0] seq, logic ok);
        send_request(seq, ok, HANDLE_W'($urandom), LEN_W'($urandom_range(0, 1024)));
    endtask

    // hold the input until every predicted result is out, then let the
    // front end settle on requests that made no result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [WS_W-1:0] ws, logic [SEQ_W-1:0] last);
        drain_results();
        cfg_write(CFG_WINDOW_SIZE, CFG_DATA_W'(ws));
        cfg_write(CFG_LAST_SEQ, last);
    endtask

    // mostly well-formed requests near the expected number, some noise
    task automatic pick_request(input logic [SEQ_W-1:0] cap, output logic [SEQ_W-1:0] seq,
                                output logic ok, output bit useful);
        int               r;
        int               cand [$];
        logic [SEQ_W-1:0] hi;
        r  = $urandom_range(0, 99);
        ok = 1'b1;
        hi = sb.base + SEQ_W'(SLOTS - 1);
        if (cap < hi) begin
            hi = cap;
        end
        seq = sb.next_seq;
        if (r < 60) begin
            if (r >= 50) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (sb.held[i] && sb.base + SEQ_W'(i) >= sb.next_seq) begin
                        cand.push_back(i);
                    end
                end
            end
            if (cand.size() > 0) begin
                seq = sb.base + SEQ_W'(cand[$urandom_range(0, cand.size() - 1)]);
            end else if (hi > sb.next_seq && $urandom_range(0, 1)) begin
                seq = sb.next_seq + SEQ_W'($urandom_range(0, int'(hi - sb.next_seq)));
            end
        end else if (r < 68) begin
            ok = 1'b0;
            if ($urandom_range(0, 1)) begin
                seq = SEQ_W'($urandom);
            end
        end else if (r < 76) begin
            if (sb.next_seq > 0) begin
                seq = SEQ_W'($urandom_range(0, int'(sb.next_seq) - 1));
            end
        end else if (r < 86) begin
            seq = sb.base + SEQ_W'(SLOTS + $urandom_range(0, 300));
        end else begin
            seq = SEQ_W'($urandom);
            ok  = 1'($urandom_range(0, 1));
        end
        useful = ok && seq >= sb.next_seq && !sb.finished;
    endtask

    task automatic run_random(int target, bit pause_mid);
        int               useful_cnt;
        bit               paused;
        bit               useful;
        logic [SEQ_W-1:0] seq;
        logic             ok;
        useful_cnt = 0;
        paused     = 1'b0;
        while (useful_cnt < target) begin
            if (pause_mid && !paused && useful_cnt >= target / 2) begin
                paused = 1'b1;
                drain_results();
            end
            pick_request(16'hFFFF, seq, ok, useful);
            send_pkt(seq, ok);
            if (useful) begin
                useful_cnt++;
            end
        end
    endtask

    initial begin
        logic [WS_W-1:0]  ws_list [8];
        logic [SEQ_W-1:0] seq;
        logic             ok;
        bit               useful;
        int               guard;
        ws_list = '{4'd8, 4'd1, 4'd0, 4'd4, 4'd2, 4'd7, 4'd3, 4'd5};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass; last_seq moved out of the way first so the
        // transfer does not end on the first request
        cfg_write(CFG_WINDOW_SIZE, CFG_DATA_W'(4'd3));
        cfg_write(CFG_LAST_SEQ, 16'd65534);
        send_pkt(16'd1, 1'b0);                          // bad checksum
        send_request(16'd1, 1'b1, 16'hFFFF, 11'd1024);
        send_pkt(16'd0, 1'b1);                          // stale
        send_pkt(16'd9, 1'b1);                          // one past the slot range
        send_pkt(16'hFFFF, 1'b1);
        send_pkt(16'd4, 1'b1);                          // gap ack
        send_pkt(16'd5, 1'b1);                          // no second gap ack
        send_request(16'd4, 1'b1, 16'h0000, 11'd0);     // overwrite buffered slot
        send_pkt(16'd2, 1'b1);
        send_pkt(16'd3, 1'b1);                          // skip ahead, then flush
        reconfigure(4'd0, 16'd65534);
        send_pkt(16'd6, 1'b1);
        send_pkt(16'd8, 1'b1);
        send_pkt(16'd7, 1'b1);
        reconfigure(4'd15, 16'd65534);
        send_pkt(16'd9, 1'b1);
        send_pkt(16'd10, 1'b1);
        send_pkt(16'd11, 1'b1);
        reconfigure(4'd8, 16'd65534);
        send_pkt(16'd13, 1'b1);
        send_pkt(16'd12, 1'b1);
        send_pkt(16'd14, 1'b1);
        send_pkt(16'd15, 1'b1);
        send_pkt(16'd16, 1'b1);                         // full eight-slot flush
        reconfigure(4'd1, 16'd65534);
        send_pkt(16'd17, 1'b1);

        for (int p = 0; p < 8; p++) begin
            reconfigure(ws_list[p], (p == 5) ? 16'd1 : 16'd65534);
            if (p == 2) begin
                hold_req = 1'b1;
            end
            run_random(35, p == 3);
        end

        // finish the transfer with no idling on either side
        drain_results();
        quiet = 1'b1;
        cfg_write(CFG_WINDOW_SIZE, CFG_DATA_W'(4'd15));
        cfg_write(CFG_LAST_SEQ, sb.base + 16'd5);
        guard = 0;
        while (!sb.finished && guard < 400) begin
            pick_request(sb.last_seq, seq, ok, useful);
            send_pkt(seq, ok);
            guard++;
        end
        // after the final ack nothing more comes out
        repeat (6) begin
            pick_request(16'hFFFF, seq, ok, useful);
            send_pkt(seq, ok);
        end
        in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
